/* hdl/mlfc_pkg.sv */
// Package: shared types, constants and a helper function of the motion light fade controller.
package mlfc_pkg;

   localparam int MAX_LEVEL = 10;
   localparam int LEVEL_W   = 5;
   localparam int PRESC_W   = 9;
   localparam int ADC_W     = 10;
   localparam int CMP_W     = 10;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 10;

   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_UP   = 2'd1;
   localparam logic [1:0] DIR_DOWN = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_LUX_THRESHOLD   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ON_TIME         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PRESCALE_LIMIT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INDICATE_TIME   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HALF_LEVEL      = 3'd4;

   typedef struct packed {
      logic [ADC_W-1:0]   lux_threshold;
      logic [7:0]         on_time;
      logic [7:0]         prescale_limit;
      logic [3:0]         indicate_time;
      logic [LEVEL_W-1:0] half_level;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      lux_threshold:   10'd600,
      on_time:         8'd16,
      prescale_limit:  8'd20,
      indicate_time:   4'd5,
      half_level:      5'd5
   };

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [1:0]         fade_dir;
      logic [PRESC_W-1:0] prescaler;
      logic [7:0]         on_left;
      logic [3:0]         indicate_left;
      logic               led_green;
      logic               led_red;
   } state_type;

   localparam state_type STATE_RESET = '{
      level:         '0,
      fade_dir:      DIR_UP,
      prescaler:     '0,
      on_left:       8'd5,
      indicate_left: 4'd2,
      led_green:     1'b0,
      led_red:       1'b0
   };

   typedef struct packed {
      logic             button_one;
      logic             button_two;
      logic             motion_one;
      logic             motion_two;
      logic             tick;
      logic             adc_done;
      logic [ADC_W-1:0] adc_value;
   } req_type;

   typedef struct packed {
      logic             start_conversion;
      logic             green_led;
      logic             red_led;
      logic             pwm_write;
      logic [CMP_W-1:0] pwm_compare;
   } rsp_type;

   function automatic logic [CMP_W-1:0] compare_of(input logic [LEVEL_W-1:0] lv);
      logic [CMP_W-1:0] res;
      res = '0;
      for (int i = 0; i < CMP_W; i++) begin
         res[i] = (lv == LEVEL_W'(i + 1));
      end
      return res;
   endfunction

endpackage

/* hdl/mlfc_if.sv */
// Interfaces: request, response and register write channels.
interface mlfc_req_if;
   logic                      valid;
   logic                      ready;
   logic                      button_one;
   logic                      button_two;
   logic                      motion_one;
   logic                      motion_two;
   logic                      tick;
   logic                      adc_done;
   logic [mlfc_pkg::ADC_W-1:0] adc_value;

   modport source (
      output valid, button_one, button_two, motion_one, motion_two, tick, adc_done,
             adc_value,
      input  ready
   );
   modport sink (
      input  valid, button_one, button_two, motion_one, motion_two, tick, adc_done,
             adc_value,
      output ready
   );
endinterface

interface mlfc_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      start_conversion;
   logic                      green_led;
   logic                      red_led;
   logic                      pwm_write;
   logic [mlfc_pkg::CMP_W-1:0] pwm_compare;

   modport source (
      output valid, start_conversion, green_led, red_led, pwm_write, pwm_compare,
      input  ready
   );
   modport sink (
      input  valid, start_conversion, green_led, red_led, pwm_write, pwm_compare,
      output ready
   );
endinterface

interface mlfc_csr_if;
   logic                          valid;
   logic                          ready;
   logic [mlfc_pkg::CSR_IDX_W-1:0] index;
   logic [mlfc_pkg::CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* hdl/mlfc_csr.sv */
// Configuration register bank with indexed write port.
module mlfc_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [mlfc_pkg::CSR_IDX_W-1:0] wr_index,
   input  logic [mlfc_pkg::CSR_DAT_W-1:0] wr_data,
   output mlfc_pkg::cfg_type              cfg
);

   mlfc_pkg::cfg_type cfg_ff;
   mlfc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            mlfc_pkg::REG_LUX_THRESHOLD:   cfg_in.lux_threshold   = wr_data[9:0];
            mlfc_pkg::REG_ON_TIME:         cfg_in.on_time         = wr_data[7:0];
            mlfc_pkg::REG_PRESCALE_LIMIT:  cfg_in.prescale_limit  = wr_data[7:0];
            mlfc_pkg::REG_INDICATE_TIME:   cfg_in.indicate_time   = wr_data[3:0];
            mlfc_pkg::REG_HALF_LEVEL:      cfg_in.half_level      = wr_data[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= mlfc_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/mlfc_step.sv */
// Event handling for one request: next state and response payload.
module mlfc_step (
   input  mlfc_pkg::cfg_type   cfg,
   input  mlfc_pkg::state_type cur,
   input  mlfc_pkg::req_type   item,
   output mlfc_pkg::state_type nxt,
   output mlfc_pkg::rsp_type   res
);

   always_comb begin
      logic                         skip;
      logic                         wrote;
      logic [mlfc_pkg::LEVEL_W:0]   lvl_up;
      mlfc_pkg::state_type          st;

      st    = cur;
      skip  = 1'b0;
      wrote = 1'b0;

      if (item.motion_one) begin
         st.led_green = 1'b1;
      end
      if (item.motion_two) begin
         st.led_red = 1'b1;
      end

      if (item.adc_done) begin
         st.led_green     = ~st.led_green;
         st.led_red       = ~st.led_red;
         st.indicate_left = cfg.indicate_time;
         if (item.adc_value < cfg.lux_threshold) begin
            skip = 1'b1;
         end else begin
            st.on_left  = cfg.on_time;
            st.fade_dir = mlfc_pkg::DIR_UP;
         end
      end

      if (!skip && item.button_one) begin
         st.led_green     = 1'b1;
         st.led_red       = 1'b1;
         st.indicate_left = cfg.indicate_time;
         if (st.level > cfg.half_level) begin
            st.on_left  = '0;
            st.fade_dir = mlfc_pkg::DIR_DOWN;
         end else begin
            st.on_left  = cfg.on_time;
            st.fade_dir = mlfc_pkg::DIR_UP;
         end
      end

      lvl_up = {1'b0, st.level} + 1'b1;

      if (!skip && item.tick) begin
         if (st.indicate_left != '0) begin
            st.indicate_left = st.indicate_left - 1'b1;
            if (st.indicate_left == '0) begin
               st.led_green = 1'b0;
               st.led_red   = 1'b0;
            end
         end
         if (st.prescaler > {1'b0, cfg.prescale_limit}) begin
            st.prescaler = '0;
            if (st.on_left != '0) begin
               st.on_left = st.on_left - 1'b1;
            end else if (st.level > mlfc_pkg::LEVEL_W'(1)) begin
               st.fade_dir = mlfc_pkg::DIR_DOWN;
            end
         end else begin
            st.prescaler = st.prescaler + 1'b1;
         end
         lvl_up = {1'b0, st.level} + 1'b1;
         unique case (st.fade_dir)
            mlfc_pkg::DIR_UP: begin
               wrote = 1'b1;
               if (lvl_up >= (mlfc_pkg::LEVEL_W + 1)'(mlfc_pkg::MAX_LEVEL)) begin
                  st.level    = mlfc_pkg::LEVEL_W'(mlfc_pkg::MAX_LEVEL);
                  st.fade_dir = mlfc_pkg::DIR_NONE;
               end else begin
                  st.level = lvl_up[mlfc_pkg::LEVEL_W-1:0];
               end
            end
            mlfc_pkg::DIR_DOWN: begin
               wrote = 1'b1;
               if (st.level <= mlfc_pkg::LEVEL_W'(1)) begin
                  st.level    = '0;
                  st.fade_dir = mlfc_pkg::DIR_NONE;
               end else begin
                  st.level = st.level - 1'b1;
               end
            end
            default: ;
         endcase
      end

      nxt                  = st;
      res.start_conversion = item.button_two | item.motion_one | item.motion_two;
      res.green_led        = st.led_green;
      res.red_led          = st.led_red;
      res.pwm_write        = wrote;
      res.pwm_compare      = mlfc_pkg::compare_of(st.level);
   end

endmodule

/* hdl/motion_light_fade_controller.sv */
// Top level: request register, state update and response register.
//
//   channel | direction | carries
//   req     | in        | event flags and light reading, one wake-up per request
//   rsp     | out       | conversion start, LED states, PWM write and compare value
//   csr     | in        | register index and write data, always ready
//
// One request per cycle sustained while rsp is not stalled; a request is held in
// the input register, then goes to rsp via the single state update and rsp register.
// Synchronous active-high reset loads the register and state reset values.
// A stalled rsp holds its result; the input register still takes one more request.
module motion_light_fade_controller (
   input  logic        clock,
   input  logic        reset,
   mlfc_req_if.sink    req,
   mlfc_rsp_if.source  rsp,
   mlfc_csr_if.sink    csr
);

   mlfc_pkg::cfg_type   cfg;
   mlfc_pkg::state_type state_ff;
   mlfc_pkg::state_type state_in;
   mlfc_pkg::req_type   req_ff;
   mlfc_pkg::req_type   req_in;
   mlfc_pkg::rsp_type   rsp_ff;
   mlfc_pkg::rsp_type   rsp_in;
   logic                hold_valid_ff;
   logic                hold_valid_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                advance;
   logic                take;

   assign csr.ready = 1'b1;

   mlfc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr.valid),
      .wr_index (csr.index),
      .wr_data  (csr.data),
      .cfg      (cfg)
   );

   mlfc_step u_step (
      .cfg  (cfg),
      .cur  (state_ff),
      .item (req_ff),
      .nxt  (state_in),
      .res  (rsp_in)
   );

   assign advance   = hold_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !hold_valid_ff || advance;
   assign take      = req.valid && req.ready;

   assign req_in = '{
      button_one: req.button_one,
      button_two: req.button_two,
      motion_one: req.motion_one,
      motion_two: req.motion_two,
      tick:       req.tick,
      adc_done:   req.adc_done,
      adc_value:  req.adc_value
   };

   assign hold_valid_in = take || (hold_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= mlfc_pkg::STATE_RESET;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.start_conversion = rsp_ff.start_conversion;
   assign rsp.green_led        = rsp_ff.green_led;
   assign rsp.red_led          = rsp_ff.red_led;
   assign rsp.pwm_write        = rsp_ff.pwm_write;
   assign rsp.pwm_compare      = rsp_ff.pwm_compare;

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.level <= mlfc_pkg::LEVEL_W'(mlfc_pkg::MAX_LEVEL))
      else $error("level above maximum");

   a_dir_code: assert property (@(posedge clock) disable iff (reset)
      state_ff.fade_dir == mlfc_pkg::DIR_NONE || state_ff.fade_dir == mlfc_pkg::DIR_UP ||
      state_ff.fade_dir == mlfc_pkg::DIR_DOWN)
      else $error("fade direction holds an unused code");

   a_no_write_no_move: assert property (@(posedge clock) disable iff (reset)
      advance && !rsp_in.pwm_write |-> state_in.level == state_ff.level)
      else $error("level changed without a compare write");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff && !advance |=> hold_valid_ff && $stable(req_ff))
      else $error("stalled request lost or changed");

   a_presc_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.prescaler <= 9'd256)
      else $error("prescaler out of range");

endmodule

/* dv/mlfc_fade_checker.sv */
// Checker: predicts each fade controller response and compares it with the rsp channel.
`timescale 1ns / 1ps
module mlfc_fade_checker
   import mlfc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   mlfc_req_if  req,
   mlfc_rsp_if  rsp,
   mlfc_csr_if  csr,
   output int   mismatch_count,
   output int   responses_due
);

   cfg_type   regs;
   state_type lamp;
   rsp_type   outputs_due[$];

   function automatic logic [CMP_W-1:0] duty_of(input logic [LEVEL_W-1:0] lv);
      logic [31:0] wide;
      wide = (lv == '0) ? 32'd0 : (32'd1 << (lv - 1'b1));
      return wide[CMP_W-1:0];
   endfunction

   function automatic rsp_type step_fade(input req_type ev);
      rsp_type res;
      logic    dark;
      res = '0;
      dark = 1'b0;
      res.start_conversion = ev.button_two | ev.motion_one | ev.motion_two;
      if (ev.motion_one) lamp.led_green = 1'b1;
      if (ev.motion_two) lamp.led_red = 1'b1;
      if (ev.adc_done) begin
         lamp.led_green = ~lamp.led_green;
         lamp.led_red = ~lamp.led_red;
         lamp.indicate_left = regs.indicate_time;
         if (ev.adc_value < regs.lux_threshold) begin
            dark = 1'b1;
         end else begin
            lamp.on_left = regs.on_time;
            lamp.fade_dir = DIR_UP;
         end
      end
      if (!dark && ev.button_one) begin
         lamp.led_green = 1'b1;
         lamp.led_red = 1'b1;
         lamp.indicate_left = regs.indicate_time;
         if (lamp.level > regs.half_level) begin
            lamp.on_left = '0;
            lamp.fade_dir = DIR_DOWN;
         end else begin
            lamp.on_left = regs.on_time;
            lamp.fade_dir = DIR_UP;
         end
      end
      if (!dark && ev.tick) begin
         if (lamp.indicate_left != '0) begin
            lamp.indicate_left = lamp.indicate_left - 1'b1;
            if (lamp.indicate_left == '0) begin
               lamp.led_green = 1'b0;
               lamp.led_red = 1'b0;
            end
         end
         if (lamp.prescaler > regs.prescale_limit) begin
            lamp.prescaler = '0;
            if (lamp.on_left != '0) begin
               lamp.on_left = lamp.on_left - 1'b1;
            end else if (lamp.level > 1) begin
               lamp.fade_dir = DIR_DOWN;
            end
         end else begin
            lamp.prescaler = lamp.prescaler + 1'b1;
         end
         if (lamp.fade_dir == DIR_UP) begin
            if (lamp.level >= LEVEL_W'(MAX_LEVEL - 1)) begin
               lamp.level = LEVEL_W'(MAX_LEVEL);
               lamp.fade_dir = DIR_NONE;
            end else begin
               lamp.level = lamp.level + 1'b1;
            end
            res.pwm_write = 1'b1;
         end else if (lamp.fade_dir == DIR_DOWN) begin
            if (lamp.level <= 1) begin
               lamp.level = '0;
               lamp.fade_dir = DIR_NONE;
            end else begin
               lamp.level = lamp.level - 1'b1;
            end
            res.pwm_write = 1'b1;
         end
      end
      res.green_led = lamp.led_green;
      res.red_led = lamp.led_red;
      res.pwm_compare = duty_of(lamp.level);
      return res;
   endfunction

   function automatic int check_field(input string field, input int unsigned want, got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      req_type ev;
      if (reset) begin
         regs = CFG_RESET;
         lamp = STATE_RESET;
         outputs_due.delete();
         mismatch_count = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (outputs_due.size() == 0) begin
               $error("response with no request outstanding");
               mismatch_count++;
            end else begin
               want = outputs_due.pop_front();
               mismatch_count += check_field("start_conversion", want.start_conversion,
                                             rsp.start_conversion)
                               + check_field("green_led", want.green_led, rsp.green_led)
                               + check_field("red_led", want.red_led, rsp.red_led)
                               + check_field("pwm_write", want.pwm_write, rsp.pwm_write)
                               + check_field("pwm_compare", want.pwm_compare,
                                             rsp.pwm_compare);
            end
         end
         if (csr.valid && csr.ready) begin
            case (csr.index)
               REG_LUX_THRESHOLD:   regs.lux_threshold = csr.data;
               REG_ON_TIME:         regs.on_time = csr.data[7:0];
               REG_PRESCALE_LIMIT:  regs.prescale_limit = csr.data[7:0];
               REG_INDICATE_TIME:   regs.indicate_time = csr.data[3:0];
               REG_HALF_LEVEL:      regs.half_level = csr.data[LEVEL_W-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            ev = '{req.button_one, req.button_two, req.motion_one, req.motion_two,
                   req.tick, req.adc_done, req.adc_value};
            outputs_due.push_back(step_fade(ev));
         end
      end
      responses_due = outputs_due.size();
   end

endmodule

/* dv/tb.sv */
// Testbench top: clock, reset, request and register stimulus, and the verdict.
`timescale 1ns / 1ps
module tb;
   import mlfc_pkg::*;

   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 215;
   localparam int CYCLE_LIMIT     = 500000;

   logic    clock;
   logic    reset;
   int      mismatch_count;
   int      responses_due;
   int      cycle_count = 0;
   int      burst_left;
   cfg_type live_cfg;
   cfg_type phase_cfg[PHASES];

   mlfc_req_if req_ch();
   mlfc_rsp_if rsp_ch();
   mlfc_csr_if csr_ch();

   motion_light_fade_controller dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   mlfc_fade_checker fade_check (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .csr            (csr_ch),
      .mismatch_count (mismatch_count),
      .responses_due  (responses_due)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic req_type make_event(input bit b1, b2, m1, m2, tk, ad, input int adv);
      req_type ev;
      ev = '{b1, b2, m1, m2, tk, ad, ADC_W'(adv)};
      return ev;
   endfunction

   function automatic req_type random_event(input cfg_type c);
      req_type                    ev;
      logic [$bits(req_type)-1:0] raw;
      int                         near;
      ev = '0;
      if ($urandom_range(0, 9) == 0) begin
         raw = $bits(req_type)'($urandom);
         ev = raw;
      end else begin
         ev.tick = ($urandom_range(0, 9) < 7);
         ev.button_one = ($urandom_range(0, 99) < 6);
         ev.button_two = ($urandom_range(0, 99) < 4);
         ev.motion_one = ($urandom_range(0, 99) < 6);
         ev.motion_two = ($urandom_range(0, 99) < 6);
         ev.adc_done = ($urandom_range(0, 99) < 10);
         if ($urandom_range(0, 1) == 0) begin
            ev.adc_value = ADC_W'($urandom);
         end else begin
            near = int'(c.lux_threshold) + int'($urandom_range(0, 4)) - 2;
            if (near < 0) near = 0;
            if (near > 1023) near = 1023;
            ev.adc_value = ADC_W'(near);
         end
      end
      return ev;
   endfunction

   task automatic offer(input req_type ev);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.button_one <= ev.button_one;
      req_ch.button_two <= ev.button_two;
      req_ch.motion_one <= ev.motion_one;
      req_ch.motion_two <= ev.motion_two;
      req_ch.tick <= ev.tick;
      req_ch.adc_done <= ev.adc_done;
      req_ch.adc_value <= ev.adc_value;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (responses_due != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   task automatic program_regs(input cfg_type c);
      logic [31:0] noise;
      noise = $urandom;
      write_reg(REG_LUX_THRESHOLD, c.lux_threshold);
      write_reg(REG_ON_TIME, {noise[1:0], c.on_time});
      write_reg(REG_PRESCALE_LIMIT, {noise[3:2], c.prescale_limit});
      write_reg(REG_INDICATE_TIME, {noise[9:4], c.indicate_time});
      write_reg(REG_HALF_LEVEL, {noise[14:10], c.half_level});
      for (int k = 1; k <= 3; k++) begin
         write_reg(CSR_IDX_W'(int'(REG_HALF_LEVEL) + k), CSR_DAT_W'($urandom));
      end
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin
      int pick;
      int span;
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      // hold off long enough for the block to back up into the request side
      repeat (60) begin
         @(negedge clock);
         rsp_ch.ready <= 1'b0;
      end
      forever begin
         pick = $urandom_range(0, 9);
         span = $urandom_range(8, 40);
         repeat (span) begin
            @(negedge clock);
            if (pick == 0) rsp_ch.ready <= 1'b0;
            else if (pick < 4) rsp_ch.ready <= 1'b1;
            else rsp_ch.ready <= ($urandom_range(0, 2) != 0);
         end
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.button_one = 1'b0;
      req_ch.button_two = 1'b0;
      req_ch.motion_one = 1'b0;
      req_ch.motion_two = 1'b0;
      req_ch.tick = 1'b0;
      req_ch.adc_done = 1'b0;
      req_ch.adc_value = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      reset = 1'b1;
      burst_left = 0;

      phase_cfg[0] = CFG_RESET;
      phase_cfg[1] = '{10'd0, 8'd0, 8'd0, 4'd0, 5'd0};
      phase_cfg[2] = '{10'd1023, 8'd255, 8'd255, 4'd15, 5'd16};
      phase_cfg[3] = '{10'd300, 8'd2, 8'd1, 4'd3, 5'd8};
      phase_cfg[4] = '{10'd512, 8'd1, 8'd0, 4'd15, 5'd3};
      phase_cfg[5] = '{10'd700, 8'd4, 8'd3, 4'd7, 5'd10};
      phase_cfg[6] = '{10'd100, 8'd0, 8'd2, 4'd1, 5'd1};
      phase_cfg[7] = '{10'd800, 8'd8, 8'd5, 4'd10, 5'd5};

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // fade up from reset, dark and bright readings, button one both ways, idle tick
      offer(make_event(0, 0, 0, 0, 0, 0, 0));
      offer(make_event(0, 0, 1, 0, 0, 0, 0));
      offer(make_event(0, 0, 0, 1, 0, 0, 0));
      offer(make_event(0, 1, 0, 0, 0, 0, 0));
      repeat (3) offer(make_event(0, 0, 0, 0, 1, 0, 0));
      offer(make_event(0, 0, 0, 0, 1, 1, 1023));
      offer(make_event(0, 0, 0, 0, 0, 1, 600));
      offer(make_event(1, 0, 0, 0, 1, 1, 599));
      offer(make_event(0, 0, 0, 0, 0, 1, 0));
      offer(make_event(1, 0, 0, 0, 0, 0, 0));
      repeat (6) offer(make_event(0, 0, 0, 0, 1, 0, 0));
      offer(make_event(0, 0, 0, 0, 1, 0, 0));
      offer(make_event(1, 0, 0, 0, 0, 0, 0));
      offer(make_event(0, 0, 0, 0, 1, 0, 0));
      offer(make_event(1, 1, 1, 1, 1, 1, 1023));
      offer(make_event(1, 1, 1, 1, 1, 1, 0));

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) program_regs(phase_cfg[p]);
         live_cfg = phase_cfg[p];
         repeat (ITEMS_PER_PHASE) offer(random_event(live_cfg));
         settle();
      end

      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && responses_due == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/mlfc_pkg.sv
hdl/mlfc_if.sv
hdl/mlfc_csr.sv
hdl/mlfc_step.sv
hdl/motion_light_fade_controller.sv
dv/mlfc_fade_checker.sv
dv/tb.sv
